@@ design/bcdac_pkg.sv @@
// Package with the word types and view codes of the BCD alarm clock display controller.
package bcdac_pkg;

    localparam int DIGIT_COUNT = 6;

    localparam logic [1:0] VIEW_TIME  = 2'd0;
    localparam logic [1:0] VIEW_DATE  = 2'd1;
    localparam logic [1:0] VIEW_ALARM = 2'd2;

    localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

    typedef struct packed {
        logic       set_mode;
        logic       button_one;
        logic       button_two;
        logic [7:0] rtc_seconds;
        logic [7:0] rtc_minutes;
        logic [7:0] rtc_hours;
        logic [7:0] rtc_day_of_month;
        logic [7:0] rtc_month;
        logic [7:0] rtc_year;
    } in_word_t;

    typedef struct packed {
        logic [3:0] digit_zero;
        logic [3:0] digit_one;
        logic [3:0] digit_two;
        logic [3:0] digit_three;
        logic [3:0] digit_four;
        logic [3:0] digit_five;
        logic [1:0] view_kind;
        logic       chime;
    } out_word_t;

endpackage

@@ design/bcd_alarm_clock_display_ctrl.sv @@
// Top level of the BCD alarm clock display controller: input, update and result registers.
//
// Usage:
//   The s_ channel takes one word per main-loop pass: the mode switch, the two
//   button levels and the six packed BCD clock bytes. The m_ channel returns
//   exactly one word per input word: six display digits, the view kind and the
//   chime flag, in input order.
//   The edge that accepts the input word loads the input register; the result
//   register loads from it as soon as it is free, and m_valid rises with it.
//   Throughput is one word per cycle while the receiver does not stall; the
//   display, alarm and button state are updated by combinational logic between
//   the two registers, so the next word follows immediately.
//   When the receiver stalls, the result register holds its word, the input
//   register fills behind it, and s_ready drops only when both are occupied.
//   Reset (aresetn low, synchronous) empties both registers and clears the
//   digit store, the alarm time and the button tracking state.
module bcd_alarm_clock_display_ctrl
    import bcdac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic       in_valid_reg;
    in_word_t   in_data_reg;
    logic       out_valid_reg;
    out_word_t  out_data_reg;

    logic [3:0] digit_reg [DIGIT_COUNT];
    logic [3:0] digit_next [DIGIT_COUNT];
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;
    logic       b1_prev_reg, b1_prev_next;
    logic       b1_toggle_reg, b1_toggle_next;
    logic       b2_prev_reg, b2_prev_next;
    logic       b2_toggle_reg, b2_toggle_next;

    logic       out_free;
    logic       advance;
    logic [1:0] view_next;
    logic       chime_next;
    logic [7:0] shown_hour;
    logic [7:0] shown_minute;
    logic       top_of_hour;
    logic       alarm_hit;
    logic [3:0] hour_tens, hour_units;
    logic [3:0] minute_tens, minute_units;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Splits a binary value below 60 into decimal tens and units by compares.
    function automatic logic [7:0] to_decimal(input logic [5:0] value);
        logic [3:0] tens;
        logic [5:0] rest;
        begin
            if (value >= 6'd50) begin
                tens = 4'd5;
                rest = value - 6'd50;
            end else if (value >= 6'd40) begin
                tens = 4'd4;
                rest = value - 6'd40;
            end else if (value >= 6'd30) begin
                tens = 4'd3;
                rest = value - 6'd30;
            end else if (value >= 6'd20) begin
                tens = 4'd2;
                rest = value - 6'd20;
            end else if (value >= 6'd10) begin
                tens = 4'd1;
                rest = value - 6'd10;
            end else begin
                tens = 4'd0;
                rest = value;
            end
            to_decimal = {tens, rest[3:0]};
        end
    endfunction

    always_comb begin
        digit_next        = digit_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        b1_prev_next      = b1_prev_reg;
        b1_toggle_next    = b1_toggle_reg;
        b2_prev_next      = b2_prev_reg;
        b2_toggle_next    = b2_toggle_reg;
        view_next         = VIEW_TIME;
        hour_tens         = 4'd0;
        hour_units        = 4'd0;
        minute_tens       = 4'd0;
        minute_units      = 4'd0;

        if (!in_data_reg.set_mode) begin
            if (in_data_reg.button_one && in_data_reg.button_two) begin
                digit_next[0] = in_data_reg.rtc_hours[7:4];
                digit_next[1] = in_data_reg.rtc_hours[3:0];
                digit_next[2] = in_data_reg.rtc_minutes[7:4];
                digit_next[3] = in_data_reg.rtc_minutes[3:0];
                digit_next[4] = in_data_reg.rtc_seconds[7:4];
                digit_next[5] = in_data_reg.rtc_seconds[3:0];
                view_next     = VIEW_TIME;
            end else if (!in_data_reg.button_one) begin
                digit_next[0] = in_data_reg.rtc_month[7:4];
                digit_next[1] = in_data_reg.rtc_month[3:0];
                digit_next[2] = in_data_reg.rtc_day_of_month[7:4];
                digit_next[3] = in_data_reg.rtc_day_of_month[3:0];
                view_next     = VIEW_DATE;
            end else begin
                digit_next[0] = 4'd2;
                digit_next[1] = 4'd0;
                digit_next[2] = in_data_reg.rtc_year[7:4];
                digit_next[3] = in_data_reg.rtc_year[3:0];
                view_next     = VIEW_DATE;
            end
        end else begin
            // Two level changes of a button make one step of the alarm time.
            if (in_data_reg.button_one != b1_prev_reg) begin
                b1_prev_next   = in_data_reg.button_one;
                b1_toggle_next = !b1_toggle_reg;
                if (b1_toggle_reg) begin
                    alarm_hour_next = (alarm_hour_reg + 5'd1 >= HOURS_PER_DAY) ?
                                      5'd0 : alarm_hour_reg + 5'd1;
                end
            end else if (in_data_reg.button_two != b2_prev_reg) begin
                b2_prev_next   = in_data_reg.button_two;
                b2_toggle_next = !b2_toggle_reg;
                if (b2_toggle_reg) begin
                    alarm_minute_next = (alarm_minute_reg + 6'd1 >= MINUTES_PER_HOUR) ?
                                        6'd0 : alarm_minute_reg + 6'd1;
                end
            end
            {hour_tens, hour_units}     = to_decimal({1'b0, alarm_hour_next});
            {minute_tens, minute_units} = to_decimal(alarm_minute_next);
            digit_next[0] = hour_tens;
            digit_next[1] = hour_units;
            digit_next[2] = minute_tens;
            digit_next[3] = minute_units;
            view_next     = VIEW_ALARM;
        end
    end

    // The chime looks at the digits after this word's update.
    assign shown_hour   = {1'b0, digit_next[0], 3'b000} + {3'b000, digit_next[0], 1'b0}
                        + {4'b0000, digit_next[1]};
    assign shown_minute = {1'b0, digit_next[2], 3'b000} + {3'b000, digit_next[2], 1'b0}
                        + {4'b0000, digit_next[3]};
    assign top_of_hour  = (digit_next[2] == 4'd0) && (digit_next[3] == 4'd0)
                        && (digit_next[4] == 4'd0) && (digit_next[5] < 4'd2);
    assign alarm_hit    = (shown_hour == {3'b000, alarm_hour_reg})
                        && (shown_minute == {2'b00, alarm_minute_reg})
                        && (digit_next[4] == 4'd0) && (digit_next[5] < 4'd2);
    assign chime_next   = !in_data_reg.set_mode && (top_of_hour || alarm_hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            alarm_hour_reg   <= 5'd0;
            alarm_minute_reg <= 6'd0;
            b1_prev_reg      <= 1'b0;
            b1_toggle_reg    <= 1'b0;
            b2_prev_reg      <= 1'b0;
            b2_toggle_reg    <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_reg[i] <= 4'd0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                alarm_hour_reg   <= alarm_hour_next;
                alarm_minute_reg <= alarm_minute_next;
                b1_prev_reg      <= b1_prev_next;
                b1_toggle_reg    <= b1_toggle_next;
                b2_prev_reg      <= b2_prev_next;
                b2_toggle_reg    <= b2_toggle_next;
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    digit_reg[i] <= digit_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg.digit_zero  <= digit_next[0];
            out_data_reg.digit_one   <= digit_next[1];
            out_data_reg.digit_two   <= digit_next[2];
            out_data_reg.digit_three <= digit_next[3];
            out_data_reg.digit_four  <= digit_next[4];
            out_data_reg.digit_five  <= digit_next[5];
            out_data_reg.view_kind   <= view_next;
            out_data_reg.chime       <= chime_next;
        end
    end

`ifndef SYNTHESIS
    a_alarm_hour_range : assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_hour_reg < HOURS_PER_DAY)
        else $error("alarm hour out of range");

    a_alarm_minute_range : assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_minute_reg < MINUTES_PER_HOUR)
        else $error("alarm minute out of range");

    a_no_chime_in_set : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.view_kind == VIEW_ALARM) |-> !m_data.chime)
        else $error("chime raised in alarm setting view");

    a_alarm_digits : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.view_kind == VIEW_ALARM)
        |-> (m_data.digit_zero <= 4'd2) && (m_data.digit_two <= 4'd5))
        else $error("alarm view shows digits beyond the alarm range");

    a_state_holds_on_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(alarm_hour_reg) && $stable(alarm_minute_reg))
        else $error("alarm time changed without a word moving");
`endif

endmodule
